/* hdl/tpg_pkg.sv */
// Shared widths, register codes and unit request/response types of the profile generator.
package tpg_pkg;

  localparam int DataW      = 16;
  localparam int FinishW    = DataW + 1;
  localparam int AccW       = 32;
  localparam int BrakeNumW  = 26;
  localparam int QuoW       = 16;
  localparam int DivNumW    = 32;
  localparam int DivDenW    = 32;
  localparam int DivCntW    = $clog2(QuoW);
  localparam int McandW     = DataW + 1;
  localparam int McW        = McandW + DataW;
  localparam int ProdW      = AccW + 2;
  localparam int MulCntW    = $clog2(DataW);
  localparam int CfgIdxW    = 2;

  localparam int UnitsPerStep = 2000;
  localparam int MsPerS       = 1000;

  localparam logic [DataW-1:0] TickMsRst  = DataW'(10);
  localparam logic [DataW-1:0] RampMsRst  = DataW'(1000);
  localparam logic [DataW-1:0] CruiseRst  = DataW'(1000);

  localparam logic [CfgIdxW-1:0] CfgTickMs = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgRampMs = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgCruise = 2'd2;

  localparam logic OpStart = 1'b0;
  localparam logic OpTick  = 1'b1;

  typedef struct packed {
    logic               start;
    logic [DivNumW-1:0] num;
    logic [DivDenW-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic            busy;
    logic            done;
    logic [QuoW-1:0] quo;
  } div_rsp_t;

  typedef struct packed {
    logic              start;
    logic [McandW-1:0] mcand;
    logic [DataW-1:0]  mplier;
    logic [AccW-1:0]   addend;
  } mul_req_t;

  typedef struct packed {
    logic             busy;
    logic             done;
    logic [ProdW-1:0] prod;
  } mul_rsp_t;

endpackage

/* hdl/tpg_if.sv */
// Valid/ready channel interfaces: configuration writes, input words and result words.
interface tpg_cfg_if;
  import tpg_pkg::*;
  logic               valid;
  logic               ready;
  logic [CfgIdxW-1:0] index;
  logic [DataW-1:0]   data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

interface tpg_in_if;
  import tpg_pkg::*;
  logic             valid;
  logic             ready;
  logic             opcode;
  logic [DataW-1:0] distance;
  modport source (output valid, output opcode, output distance, input ready);
  modport sink   (input valid, input opcode, input distance, output ready);
endinterface

interface tpg_out_if;
  import tpg_pkg::*;
  logic             valid;
  logic             ready;
  logic [DataW-1:0] position;
  logic [DataW-1:0] velocity;
  logic [DataW-1:0] step_count;
  logic             idle;
  modport source (output valid, output position, output velocity, output step_count,
                  output idle, input ready);
  modport sink   (input valid, input position, input velocity, input step_count,
                  input idle, output ready);
endinterface

/* hdl/tpg_div.sv */
// Bit-serial restoring divider, 16 quotient bits, saturating at all ones.
module tpg_div (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  tpg_pkg::div_req_t req_i,
  output tpg_pkg::div_rsp_t rsp_o
);
  import tpg_pkg::*;

  logic                 busy_q;
  logic                 done_q;
  logic [DivCntW-1:0]   cnt_q;
  logic [DivDenW-1:0]   rem_q;
  logic [DivDenW-1:0]   den_q;
  logic [QuoW-1:0]      num_q;
  logic [QuoW-1:0]      quo_q;
  logic [DivDenW:0]     shifted;
  logic [DivDenW+1:0]   diff;
  logic                 qbit;
  logic                 ovf;
  logic [DivDenW-1:0]   rem_d;

  // quotient would not fit in 16 bits, or divisor is zero
  assign ovf = (req_i.den == '0) ||
               (DivDenW'(req_i.num[DivNumW-1:QuoW]) >= req_i.den);

  assign shifted = {rem_q, num_q[QuoW-1]};
  assign diff    = (DivDenW+2)'(shifted) - (DivDenW+2)'(den_q);
  assign qbit    = ~diff[DivDenW+1];
  assign rem_d   = qbit ? diff[DivDenW-1:0] : shifted[DivDenW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        cnt_q <= '0;
        if (ovf) begin
          done_q <= 1'b1;
        end else begin
          busy_q <= 1'b1;
        end
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == DivCntW'(QuoW - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      rem_q <= DivDenW'(req_i.num[DivNumW-1:QuoW]);
      num_q <= req_i.num[QuoW-1:0];
      den_q <= req_i.den;
      quo_q <= ovf ? '1 : '0;
    end else if (busy_q) begin
      rem_q <= rem_d;
      num_q <= {num_q[QuoW-2:0], 1'b0};
      quo_q <= {quo_q[QuoW-2:0], qbit};
    end
  end

  assign rsp_o.busy = busy_q;
  assign rsp_o.done = done_q;
  assign rsp_o.quo  = quo_q;

endmodule

/* hdl/tpg_mul.sv */
// Bit-serial shift-add multiplier with a preloaded addend.
module tpg_mul (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  tpg_pkg::mul_req_t req_i,
  output tpg_pkg::mul_rsp_t rsp_o
);
  import tpg_pkg::*;

  logic               busy_q;
  logic               done_q;
  logic [MulCntW-1:0] cnt_q;
  logic [ProdW-1:0]   acc_q;
  logic [McW-1:0]     mc_q;
  logic [DataW-1:0]   mp_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == MulCntW'(DataW - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      acc_q <= ProdW'(req_i.addend);
      mc_q  <= McW'(req_i.mcand);
      mp_q  <= req_i.mplier;
    end else if (busy_q) begin
      if (mp_q[0]) begin
        acc_q <= acc_q + ProdW'(mc_q);
      end
      mc_q <= {mc_q[McW-2:0], 1'b0};
      mp_q <= {1'b0, mp_q[DataW-1:1]};
    end
  end

  assign rsp_o.busy = busy_q;
  assign rsp_o.done = done_q;
  assign rsp_o.prod = acc_q;

endmodule

/* hdl/trapezoid_profile_generator.sv */
// Trapezoidal speed/position profile generator, top level.
//
//   channel  dir  handshake        payload
//   cfg_i    in   valid / ready    index[1:0], data[15:0]
//   in_i     in   valid / ready    opcode, distance[15:0]
//   out_o    out  valid / ready    position, velocity, step_count, idle
//
// A start word runs three 16-step serial divisions and one 16-step serial multiply,
// back to back on the shared divider and multiplier.
// A tick word runs one serial multiply-accumulate and one division by 2000; a tick
// that finishes the move skips both and goes straight to the emit.
// Reset clears the move state and loads the register defaults; no clearing pass.
// in_i is ready whenever no word is in work; a result waiting in the output register
// stalls only the emit of the next result. cfg_i is always ready.
module trapezoid_profile_generator (
  input  logic      clk_i,
  input  logic      rst_ni,
  tpg_cfg_if.sink   cfg_i,
  tpg_in_if.sink    in_i,
  tpg_out_if.source out_o
);
  import tpg_pkg::*;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_RDIV = 4'd1;
  localparam logic [3:0] S_SDIV = 4'd2;
  localparam logic [3:0] S_BMUL = 4'd3;
  localparam logic [3:0] S_BDIV = 4'd4;
  localparam logic [3:0] S_TICK = 4'd5;
  localparam logic [3:0] S_TMUL = 4'd6;
  localparam logic [3:0] S_PDIV = 4'd7;
  localparam logic [3:0] S_EMIT = 4'd8;

  logic [3:0]         state_q, state_d;
  logic [DataW-1:0]   tick_ms_q, ramp_ms_q, cruise_q;
  logic [DataW-1:0]   tick_q, ramp_q, brake_q, step_q, speed_q, target_q, latch_q;
  logic [DataW-1:0]   res_pos_q;
  logic [FinishW-1:0] finish_q;
  logic [AccW-1:0]    acc_q;
  logic               idle_q;

  logic               out_valid_q;
  logic [DataW-1:0]   out_pos_q, out_vel_q, out_cnt_q;
  logic               out_idle_q;

  div_req_t           div_req;
  div_rsp_t           div_rsp;
  mul_req_t           mul_req;
  mul_rsp_t           mul_rsp;

  logic               in_accept;
  logic               emit_ok;
  logic [DataW-1:0]   tick_next;
  logic [DataW-1:0]   speed_tick;
  logic               tick_done;
  logic [DataW-1:0]   ramp_sel;
  logic [McandW-1:0]  speed_sum;
  logic [AccW-1:0]    acc_sat;
  logic [BrakeNumW-1:0] brake_num;

  tpg_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  tpg_mul u_mul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mul_req),
    .rsp_o  (mul_rsp)
  );

  assign cfg_i.ready = 1'b1;
  assign in_i.ready  = (state_q == S_IDLE);
  assign in_accept   = in_i.valid & in_i.ready;
  assign emit_ok     = (state_q == S_EMIT) && (!out_valid_q || out_o.ready);

  // tick rules
  assign tick_next = (tick_q != '1) ? tick_q + 1'b1 : tick_q;

  always_comb begin
    tick_done = 1'b0;
    if (tick_next <= ramp_q) begin
      speed_tick = speed_q + step_q;
    end else if (tick_next <= brake_q) begin
      speed_tick = cruise_q;
    end else if (FinishW'(tick_next) <= finish_q) begin
      speed_tick = (speed_q >= step_q) ? speed_q - step_q : '0;
    end else begin
      speed_tick = '0;
      tick_done  = 1'b1;
    end
  end

  assign ramp_sel  = (div_rsp.quo == '0) ? DataW'(1) : div_rsp.quo;
  assign speed_sum = McandW'(speed_q) + McandW'(speed_tick);
  assign acc_sat   = (mul_rsp.prod[ProdW-1:AccW] != '0) ? '1 : mul_rsp.prod[AccW-1:0];
  assign brake_num = BrakeNumW'(target_q) * BrakeNumW'(MsPerS);

  always_comb begin
    state_d = state_q;
    div_req = '0;
    mul_req = '0;
    case (state_q)
      S_IDLE: begin
        if (in_accept) begin
          if (in_i.opcode == OpStart) begin
            div_req.start = 1'b1;
            div_req.num   = DivNumW'(ramp_ms_q);
            div_req.den   = DivDenW'(tick_ms_q);
            state_d       = S_RDIV;
          end else begin
            state_d = S_TICK;
          end
        end
      end
      S_RDIV: begin
        if (div_rsp.done) begin
          div_req.start = 1'b1;
          div_req.num   = DivNumW'(cruise_q);
          div_req.den   = DivDenW'(ramp_sel);
          state_d       = S_SDIV;
        end
      end
      S_SDIV: begin
        if (div_rsp.done) begin
          mul_req.start  = 1'b1;
          mul_req.mcand  = McandW'(cruise_q);
          mul_req.mplier = tick_ms_q;
          state_d        = S_BMUL;
        end
      end
      S_BMUL: begin
        if (mul_rsp.done) begin
          div_req.start = 1'b1;
          div_req.num   = DivNumW'(brake_num);
          div_req.den   = mul_rsp.prod[DivDenW-1:0];
          state_d       = S_BDIV;
        end
      end
      S_BDIV: begin
        if (div_rsp.done) begin
          state_d = S_EMIT;
        end
      end
      S_TICK: begin
        if (tick_done) begin
          state_d = S_EMIT;
        end else begin
          mul_req.start  = 1'b1;
          mul_req.mcand  = speed_sum;
          mul_req.mplier = latch_q;
          mul_req.addend = acc_q;
          state_d        = S_TMUL;
        end
      end
      S_TMUL: begin
        if (mul_rsp.done) begin
          div_req.start = 1'b1;
          div_req.num   = acc_sat;
          div_req.den   = DivDenW'(UnitsPerStep);
          state_d       = S_PDIV;
        end
      end
      S_PDIV: begin
        if (div_rsp.done) begin
          state_d = S_EMIT;
        end
      end
      S_EMIT: begin
        if (emit_ok) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      tick_ms_q <= TickMsRst;
      ramp_ms_q <= RampMsRst;
      cruise_q  <= CruiseRst;
      tick_q    <= '0;
      ramp_q    <= '0;
      brake_q   <= '0;
      finish_q  <= '0;
      step_q    <= '0;
      speed_q   <= '0;
      acc_q     <= '0;
      target_q  <= '0;
      idle_q    <= 1'b1;
      latch_q   <= TickMsRst;
      res_pos_q <= '0;
    end else begin
      state_q <= state_d;
      if (cfg_i.valid && cfg_i.ready) begin
        case (cfg_i.index)
          CfgTickMs: tick_ms_q <= cfg_i.data;
          CfgRampMs: ramp_ms_q <= cfg_i.data;
          CfgCruise: cruise_q  <= cfg_i.data;
          default: ;
        endcase
      end
      case (state_q)
        S_IDLE: begin
          if (in_accept && (in_i.opcode == OpStart)) begin
            target_q <= in_i.distance;
          end
        end
        S_RDIV: begin
          if (div_rsp.done) begin
            ramp_q <= ramp_sel;
          end
        end
        S_SDIV: begin
          if (div_rsp.done) begin
            step_q <= div_rsp.quo;
          end
        end
        S_BDIV: begin
          if (div_rsp.done) begin
            brake_q   <= div_rsp.quo;
            finish_q  <= FinishW'(div_rsp.quo) + FinishW'(ramp_q);
            tick_q    <= '0;
            speed_q   <= '0;
            acc_q     <= '0;
            idle_q    <= 1'b0;
            latch_q   <= tick_ms_q;
            res_pos_q <= '0;
          end
        end
        S_TICK: begin
          tick_q  <= tick_next;
          speed_q <= speed_tick;
          if (tick_done) begin
            acc_q     <= AccW'(target_q) * AccW'(UnitsPerStep);
            idle_q    <= 1'b1;
            res_pos_q <= target_q;
          end else begin
            idle_q <= 1'b0;
          end
        end
        S_TMUL: begin
          if (mul_rsp.done) begin
            acc_q <= acc_sat;
          end
        end
        S_PDIV: begin
          if (div_rsp.done) begin
            res_pos_q <= div_rsp.quo;
          end
        end
        default: ;
      endcase
    end
  end

  // output register: hold the word until taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (emit_ok) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit_ok) begin
      out_pos_q  <= res_pos_q;
      out_vel_q  <= speed_q;
      out_cnt_q  <= tick_q;
      out_idle_q <= idle_q;
    end
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.position   = out_pos_q;
  assign out_o.velocity   = out_vel_q;
  assign out_o.step_count = out_cnt_q;
  assign out_o.idle       = out_idle_q;

  a_div_start_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_req.start |-> !div_rsp.busy)
    else $error("divider started while busy");

  a_mul_start_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mul_req.start |-> !mul_rsp.busy)
    else $error("multiplier started while busy");

  a_idle_at_rest: assert property (@(posedge clk_i) disable iff (!rst_ni)
    idle_q |-> (speed_q == '0))
    else $error("idle with nonzero speed");

  a_ramp_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SDIV) |-> (ramp_q != '0))
    else $error("ramp length zero before speed step division");

endmodule

/* dv/trapezoid_profile_generator_tb.sv */
// Self-checking testbench for the trapezoid profile generator: directed moves, then random moves.
module trapezoid_profile_generator_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import tpg_pkg::*;

  localparam logic [CfgIdxW-1:0] CfgUnused = 2'd3;
  localparam int QuietLimit = 4000;
  localparam int HoldCycles = 500;
  localparam int RandomWords = 600;

  typedef struct packed {
    logic             opcode;
    logic [DataW-1:0] distance;
  } move_word_t;

  typedef struct packed {
    logic [DataW-1:0] position;
    logic [DataW-1:0] velocity;
    logic [DataW-1:0] step_count;
    logic             idle;
  } setpoint_t;

  logic clk = 1'b0;
  logic rst_n;

  tpg_cfg_if cfg ();
  tpg_in_if  mv ();
  tpg_out_if sp ();

  trapezoid_profile_generator dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .cfg_i  (cfg),
    .in_i   (mv),
    .out_o  (sp)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // register mirror and move state of the profile predictor
  logic [DataW-1:0]   cfg_tick_ms     = TickMsRst;
  logic [DataW-1:0]   cfg_ramp_ms     = RampMsRst;
  logic [DataW-1:0]   cfg_cruise      = CruiseRst;
  logic [DataW-1:0]   prof_tick       = '0;
  logic [DataW-1:0]   prof_ramp_end   = '0;
  logic [DataW-1:0]   prof_brake      = '0;
  logic [FinishW-1:0] prof_finish     = '0;
  logic [DataW-1:0]   prof_speed_step = '0;
  logic [DataW-1:0]   prof_speed      = '0;
  logic [AccW-1:0]    prof_pos_acc    = '0;
  logic [DataW-1:0]   prof_target     = '0;
  logic               prof_idle       = 1'b1;
  logic [DataW-1:0]   prof_tick_latch = TickMsRst;

  move_word_t pending_words[$];
  setpoint_t  setpoints_due[$];
  move_word_t next_word;

  int failures        = 0;
  int words_sent      = 0;
  int results_checked = 0;
  int moves_started   = 0;
  int reg_writes      = 0;
  int random_words    = 0;

  // idling controls, set per phase
  int          gap_max       = 0;
  int          gap_left      = 0;
  int          burst_left    = 0;
  logic [15:0] ready_pattern = 16'hFFFF;
  logic [3:0]  ready_slot    = '0;
  int          holdoff_asked = 0;
  int          holdoff_taken = 0;
  int          hold_left     = 0;

  function automatic void derive_move(input logic [DataW-1:0] travel,
                                      output logic [DataW-1:0] ramp_end,
                                      output logic [DataW-1:0] speed_step,
                                      output logic [DataW-1:0] brake);
    logic [63:0] quo;
    logic [63:0] den;
    // a zero divisor reads as all ones
    quo = (cfg_tick_ms == '0) ? 64'd65535 : 64'(cfg_ramp_ms) / 64'(cfg_tick_ms);
    if (quo == 64'd0) quo = 64'd1;
    ramp_end   = quo[DataW-1:0];
    speed_step = cfg_cruise / ramp_end;
    den = 64'(cfg_cruise) * 64'(cfg_tick_ms);
    quo = (den == 64'd0) ? 64'd65535 : 64'(travel) * 64'(MsPerS) / den;
    if (quo > 64'd65535) quo = 64'd65535;
    brake = quo[DataW-1:0];
  endfunction

  function automatic setpoint_t advance_profile(input logic op, input logic [DataW-1:0] travel);
    setpoint_t        res;
    logic [DataW-1:0] prev;
    logic [63:0]      acc;
    logic [AccW-1:0]  whole;
    logic             finished;
    if (op == OpStart) begin
      derive_move(travel, prof_ramp_end, prof_speed_step, prof_brake);
      prof_finish     = {1'b0, prof_brake} + {1'b0, prof_ramp_end};
      prof_tick       = '0;
      prof_target     = travel;
      prof_tick_latch = cfg_tick_ms;
      prof_speed      = '0;
      prof_pos_acc    = '0;
      prof_idle       = 1'b0;
    end else begin
      prev     = prof_speed;
      finished = 1'b0;
      if (prof_tick != 16'hFFFF) prof_tick = prof_tick + 16'd1;
      if (prof_tick <= prof_ramp_end) begin
        prof_speed = prof_speed + prof_speed_step;
      end else if (prof_tick <= prof_brake) begin
        prof_speed = cfg_cruise;
      end else if ({1'b0, prof_tick} <= prof_finish) begin
        prof_speed = (prof_speed >= prof_speed_step) ? prof_speed - prof_speed_step : '0;
      end else begin
        prof_speed = '0;
        finished   = 1'b1;
      end
      if (!finished) begin
        acc = 64'(prof_pos_acc) + (64'(prof_speed) + 64'(prev)) * 64'(prof_tick_latch);
        prof_pos_acc = (acc > 64'hFFFF_FFFF) ? '1 : acc[AccW-1:0];
        prof_idle    = 1'b0;
      end else begin
        prof_pos_acc = 32'(prof_target) * 32'(UnitsPerStep);
        prof_idle    = 1'b1;
      end
    end
    whole          = prof_pos_acc / 32'(UnitsPerStep);
    res.position   = (whole > 32'hFFFF) ? '1 : whole[DataW-1:0];
    res.velocity   = prof_speed;
    res.step_count = prof_tick;
    res.idle       = prof_idle;
    return res;
  endfunction

  function automatic void note_mismatch(input string name, input logic [DataW-1:0] want,
                                        input logic [DataW-1:0] got);
    failures++;
    // keep the log readable when everything goes wrong
    if (failures <= 100) $error("%s: expected %0d, got %0d", name, want, got);
  endfunction

  function automatic void push_word(input logic op, input logic [DataW-1:0] travel);
    pending_words.push_back(move_word_t'{opcode: op, distance: travel});
    if (op == OpStart) moves_started++;
  endfunction

  task automatic program_regs(input logic [DataW-1:0] tick, input logic [DataW-1:0] ramp,
                              input logic [DataW-1:0] cruise, input bit poke_unused);
    logic [CfgIdxW-1:0] idx [4];
    logic [DataW-1:0]   val [4];
    int                 n;
    idx = '{CfgTickMs, CfgRampMs, CfgCruise, CfgUnused};
    val = '{tick, ramp, cruise, 16'($urandom)};
    n = poke_unused ? 4 : 3;
    for (int k = 0; k < n; k++) begin
      cfg.valid <= 1'b1;
      cfg.index <= idx[k];
      cfg.data  <= val[k];
      do @(posedge clk); while (!cfg.ready);
      case (idx[k])
        CfgTickMs: cfg_tick_ms = val[k];
        CfgRampMs: cfg_ramp_ms = val[k];
        CfgCruise: cfg_cruise  = val[k];
        default: ;
      endcase
      reg_writes++;
    end
    cfg.valid <= 1'b0;
  endtask

  task automatic wait_drained();
    while (pending_words.size() != 0 || mv.valid || setpoints_due.size() != 0)
      @(posedge clk);
  endtask

  task automatic queue_random_moves(input int budget);
    logic [DataW-1:0] travel;
    logic [DataW-1:0] ramp_end;
    logic [DataW-1:0] speed_step;
    logic [DataW-1:0] brake;
    longint unsigned  reach;
    int               span;
    int               n;
    while (budget > 0) begin
      // keep most moves short: brake index within about 40 ticks
      reach = 64'(cfg_cruise) * 64'(cfg_tick_ms) * 40 / 1000;
      if (reach == 0 || reach > 65535 || $urandom_range(0, 9) == 0) reach = 65535;
      travel = 16'($urandom_range(0, int'(reach)));
      derive_move(travel, ramp_end, speed_step, brake);
      span = int'(ramp_end) + int'(brake) + 1;
      if (span > 60) n = $urandom_range(1, 20);
      else n = span + (($urandom_range(0, 9) == 0) ? $urandom_range(1, 5) : 0);
      // cut some moves short with a fresh start
      if ($urandom_range(0, 7) == 0) n = $urandom_range(0, n);
      push_word(OpStart, travel);
      repeat (n) push_word(OpTick, 16'($urandom));
      budget       -= n + 1;
      random_words += n + 1;
    end
  endtask

  // input driver: bursts of words with random gaps
  always @(posedge clk) begin
    if (rst_n) begin
      if (mv.valid && mv.ready) begin
        setpoints_due.push_back(advance_profile(mv.opcode, mv.distance));
        words_sent++;
      end
      if (!mv.valid || mv.ready) begin
        if (gap_left > 0) begin
          gap_left--;
          mv.valid <= 1'b0;
        end else if (pending_words.size() > 0) begin
          next_word = pending_words.pop_front();
          mv.valid    <= 1'b1;
          mv.opcode   <= next_word.opcode;
          mv.distance <= next_word.distance;
          if (burst_left > 1) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(1, 24);
            gap_left   = (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
          end
        end else begin
          mv.valid <= 1'b0;
        end
      end
    end
  end

  // result monitor and receiver stalls
  always @(posedge clk) begin
    setpoint_t want;
    if (rst_n) begin
      if (sp.valid && sp.ready) begin
        if (setpoints_due.size() == 0) begin
          failures++;
          $error("result word with nothing expected: position %0d velocity %0d", sp.position,
                 sp.velocity);
        end else begin
          want = setpoints_due.pop_front();
          if (sp.position !== want.position) note_mismatch("position", want.position, sp.position);
          if (sp.velocity !== want.velocity) note_mismatch("velocity", want.velocity, sp.velocity);
          if (sp.step_count !== want.step_count)
            note_mismatch("step_count", want.step_count, sp.step_count);
          if (sp.idle !== want.idle)
            note_mismatch("idle", DataW'(want.idle), DataW'(sp.idle));
          results_checked++;
        end
      end
      if (hold_left > 0) begin
        hold_left--;
      end else if (holdoff_taken != holdoff_asked) begin
        hold_left = HoldCycles;
        holdoff_taken++;
      end
      ready_slot = ready_slot + 4'd1;
      sp.ready <= (hold_left == 0) && ready_pattern[ready_slot];
    end
  end

  initial begin
    int quiet;
    quiet = 0;
    while (quiet < QuietLimit) begin
      @(posedge clk);
      if (!rst_n || (mv.valid && mv.ready) || (sp.valid && sp.ready) || (cfg.valid && cfg.ready))
        quiet = 0;
      else
        quiet++;
    end
    $error("no word moved for %0d cycles", QuietLimit);
    $display("status: fail");
    $finish;
  end

  initial begin
    int               phase;
    logic [DataW-1:0] tick;
    logic [DataW-1:0] ramp;
    logic [DataW-1:0] cruise;
    longint unsigned  ramp_top;
    cfg.valid   = 1'b0;
    cfg.index   = CfgTickMs;
    cfg.data    = '0;
    mv.valid    = 1'b0;
    mv.opcode   = OpTick;
    mv.distance = '0;
    sp.ready    = 1'b0;
    rst_n       = 1'b0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // reset settings: ticks before any start finish at once, then keep counting
    gap_max       <= 6;
    ready_pattern <= 16'hB5AF;
    push_word(OpTick, 16'hFFFF);
    push_word(OpTick, 16'h0000);
    push_word(OpStart, 16'hFFFF);
    repeat (3) push_word(OpTick, 16'h5A5A);
    push_word(OpStart, 16'h0000);
    repeat (2) push_word(OpTick, 16'hA5A5);
    wait_drained();

    // shortest tick: ramp up, ramp down without cruise, then a full trapezoid
    program_regs(16'd1, 16'd3, 16'hFFFF, 1'b1);
    push_word(OpStart, 16'd200);
    repeat (8) push_word(OpTick, 16'($urandom));
    push_word(OpStart, 16'd400);
    repeat (11) push_word(OpTick, 16'($urandom));
    wait_drained();

    // zero tick period and zero cruise speed: divisions read as all ones
    program_regs(16'd0, 16'hFFFF, 16'd0, 1'b0);
    push_word(OpStart, 16'd1234);
    repeat (3) push_word(OpTick, 16'($urandom));
    wait_drained();

    // ramp length clamps to one; zero product with a nonzero period
    program_regs(16'hFFFF, 16'd0, 16'd0, 1'b0);
    push_word(OpStart, 16'hFFFF);
    repeat (2) push_word(OpTick, 16'($urandom));
    wait_drained();

    // long ramp at full speed: position saturates, then the accumulator does
    program_regs(16'd1000, 16'hFFFF, 16'hFFFF, 1'b0);
    push_word(OpStart, 16'hFFFF);
    repeat (68) push_word(OpTick, 16'($urandom));
    wait_drained();

    // short move, then ticks well past the finish
    gap_max       <= 0;
    ready_pattern <= 16'hFFFF;
    program_regs(16'd1, 16'd1, 16'd1, 1'b1);
    push_word(OpStart, 16'd0);
    repeat (20) push_word(OpTick, 16'($urandom));
    wait_drained();

    phase = 0;
    while (random_words < RandomWords) begin
      case ($urandom_range(0, 3))
        0: begin
          tick   = 16'($urandom_range(1, 20));
          cruise = 16'($urandom_range(1, 65535));
        end
        1: begin
          tick   = 16'($urandom_range(1, 65535));
          cruise = 16'($urandom_range(1, 65535));
        end
        2: begin
          tick   = 16'($urandom_range(1, 200));
          cruise = 16'($urandom_range(1, 500));
        end
        default: begin
          tick   = 16'($urandom);
          cruise = 16'($urandom);
        end
      endcase
      ramp_top = 64'(tick) * 20;
      if (ramp_top > 65535) ramp_top = 65535;
      ramp = 16'($urandom_range(0, int'(ramp_top)));
      program_regs(tick, ramp, cruise, $urandom_range(0, 3) == 0);

      if (phase == 1 || phase % 3 == 0) gap_max <= 0;
      else gap_max <= $urandom_range(2, 45);
      case ($urandom_range(0, 2))
        0:       ready_pattern <= 16'hFFFF;
        1:       ready_pattern <= 16'($urandom) | 16'h0001;
        default: ready_pattern <= (16'($urandom) & 16'($urandom)) | 16'h0001;
      endcase
      queue_random_moves($urandom_range(40, 110));
      // stall the receiver long enough for the block to back up onto its input
      if (phase == 1) holdoff_asked <= holdoff_asked + 1;
      wait_drained();
      phase++;
    end

    repeat (100) @(posedge clk);
    if (setpoints_due.size() != 0) begin
      failures++;
      $error("%0d results never arrived", setpoints_due.size());
    end
    $display("run: %0d moves over %0d words (%0d random), %0d results checked",
             moves_started, words_sent, random_words, results_checked);
    $display("run: %0d register writes, %0d random setups, %0d long receiver hold-offs",
             reg_writes, phase, holdoff_taken);
    if (failures == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

/* sim.f */
hdl/tpg_pkg.sv
hdl/tpg_if.sv
hdl/tpg_div.sv
hdl/tpg_mul.sv
hdl/trapezoid_profile_generator.sv
dv/trapezoid_profile_generator_tb.sv
